// ----- hw/rtl/rsurf_pkg.sv -----
`default_nettype none
package rsurf_pkg;

   localparam int MAX_POINTS  = 32;
   localparam int COORD_WIDTH = 16;
   localparam int PT_IDX_W    = 5;
   localparam int PTS_W       = 6;
   localparam int ANGLE_W     = 9;
   localparam int TRIG_W      = 16;
   localparam int FRAC_BITS   = 14;
   localparam int ROUND_HALF  = 8192;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;

   localparam int FULL_TURN    = 360;
   localparam int HALF_TURN    = 180;
   localparam int QUARTER_TURN = 90;
   localparam int THREE_QUARTER_TURN = 270;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_SELECT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP_DEG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROFILE_POINTS = 2'd2;

   // axis codes
   localparam logic [1:0] AXIS_Z = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_X = 2'd2;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EMIT = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [TRIG_W-1:0]      trig_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      logic mul_en;
      logic scale_en;
   } rot_ctrl_type;

   // sin(d) in Q2.14 for d = 0..90
   localparam logic [14:0] QSINE [0:90] = '{
      15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
      15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
      15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
      15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
      15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
      15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
      15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
      15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
      15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
      15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
      15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
      15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
      15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // sine of a whole-degree angle below two full turns, by quadrant symmetry
   function automatic trig_type sine_deg(input logic [ANGLE_W-1:0] deg);
      logic [ANGLE_W-1:0] d;
      logic [ANGLE_W-1:0] k;
      logic               neg;
      trig_type           mag;
      d = (deg >= ANGLE_W'(FULL_TURN)) ? deg - ANGLE_W'(FULL_TURN) : deg;
      if (d <= ANGLE_W'(QUARTER_TURN)) begin
         k   = d;
         neg = 1'b0;
      end else if (d <= ANGLE_W'(HALF_TURN)) begin
         k   = ANGLE_W'(HALF_TURN) - d;
         neg = 1'b0;
      end else if (d <= ANGLE_W'(THREE_QUARTER_TURN)) begin
         k   = d - ANGLE_W'(HALF_TURN);
         neg = 1'b1;
      end else begin
         k   = ANGLE_W'(FULL_TURN) - d;
         neg = 1'b1;
      end
      mag = trig_type'({1'b0, QSINE[k[6:0]]});
      return neg ? -mag : mag;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rsurf_req_if.sv -----
`default_nettype none
interface rsurf_req_if import rsurf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [PT_IDX_W-1:0] point_index;
   coord_type           px;
   coord_type           py;
   coord_type           pz;
   logic [ANGLE_W-1:0]  sector;

   modport source (output valid, kind, point_index, px, py, pz, sector, input ready);
   modport sink   (input valid, kind, point_index, px, py, pz, sector, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rsurf_rsp_if.sv -----
`default_nettype none
interface rsurf_rsp_if import rsurf_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type ax;
   coord_type ay;
   coord_type az;
   coord_type bx;
   coord_type by_coord;
   coord_type bz;
   coord_type cx;
   coord_type cy;
   coord_type cz;
   logic      last_triangle;

   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_triangle,
                   input ready);
   modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_triangle,
                   output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rsurf_profile_mem.sv -----
`default_nettype none
module rsurf_profile_mem import rsurf_pkg::*; (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [PT_IDX_W-1:0] wr_addr,
   input  wire point_type           wr_data,
   input  wire logic                rd_en,
   input  wire logic [PT_IDX_W-1:0] rd_addr,
   output point_type                rd_data
);

   point_type mem [0:MAX_POINTS-1];
   point_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/rsurf_rotate.sv -----
`default_nettype none
module rsurf_rotate import rsurf_pkg::*; (
   input  wire logic         clock,
   input  wire rot_ctrl_type ctrl,
   input  wire logic [1:0]   axis,
   input  wire point_type    pt,
   input  wire trig_type     sin0,
   input  wire trig_type     cos0,
   input  wire trig_type     sin1,
   input  wire trig_type     cos1,
   output point_type         cur0,
   output point_type         cur1,
   output point_type         prev0,
   output point_type         prev1
);

   localparam int PROD_W = COORD_WIDTH + TRIG_W;
   localparam int Q_W    = PROD_W + 1 - FRAC_BITS;

   logic signed [PROD_W-1:0] mc0_ff, ms0_ff, mc1_ff, ms1_ff;
   point_type                pt_ff;
   point_type                cur0_ff, cur1_ff, prev0_ff, prev1_ff;
   point_type                cur0_in, cur1_in;
   coord_type                src;
   coord_type                sc0, ss0, sc1, ss1;

   // round half up, floor by 2^14, saturate
   function automatic coord_type scale(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W:0] p;
      logic signed [Q_W-1:0]  q;
      p = {prod[PROD_W-1], prod} + (PROD_W+1)'(ROUND_HALF);
      q = p[PROD_W:FRAC_BITS];
      if (q > Q_W'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}))) begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (q < Q_W'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}))) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end
      return q[COORD_WIDTH-1:0];
   endfunction

   assign src = (axis == AXIS_X) ? pt.z : pt.x;

   // multiply stage
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         mc0_ff <= src * cos0;
         ms0_ff <= src * sin0;
         mc1_ff <= src * cos1;
         ms1_ff <= src * sin1;
         pt_ff  <= pt;
      end
   end

   assign sc0 = scale(mc0_ff);
   assign ss0 = scale(ms0_ff);
   assign sc1 = scale(mc1_ff);
   assign ss1 = scale(ms1_ff);

   // place the turned coordinates per axis
   always_comb begin
      unique case (axis)
         AXIS_Z: begin
            cur0_in = '{x: sc0, y: ss0, z: pt_ff.z};
            cur1_in = '{x: sc1, y: ss1, z: pt_ff.z};
         end
         AXIS_Y: begin
            cur0_in = '{x: sc0, y: pt_ff.y, z: ss0};
            cur1_in = '{x: sc1, y: pt_ff.y, z: ss1};
         end
         default: begin
            cur0_in = '{x: pt_ff.x, y: sc0, z: ss0};
            cur1_in = '{x: pt_ff.x, y: sc1, z: ss1};
         end
      endcase
   end

   // scale stage: advance current point into previous
   always_ff @(posedge clock) begin
      if (ctrl.scale_en) begin
         prev0_ff <= cur0_ff;
         prev1_ff <= cur1_ff;
         cur0_ff  <= cur0_in;
         cur1_ff  <= cur1_in;
      end
   end

   assign cur0  = cur0_ff;
   assign cur1  = cur1_ff;
   assign prev0 = prev0_ff;
   assign prev1 = prev1_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/revolution_surface_triangulator.sv -----
`default_nettype none
// Sweeps a stored profile of up to 32 points around the x, y or z axis. A load transfer
// writes one profile point. An emit transfer returns the two triangles of every profile
// segment for one sector, one at a time on the result side. The transfer is followed by
// the setup of the sector angles and trig values. The first point then passes through a
// profile memory read, a multiply stage and a scale stage. Every further point passes
// through the same steps, followed by one result for each of its two triangles. An emit
// that yields no triangles returns to idle after the sector check. A stall on the result
// side holds the sequencer on the triangle waiting to be handed over. A new item is taken
// once the previous emit has handed its last triangle to the result register.
module revolution_surface_triangulator import rsurf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rsurf_req_if.sink                  req_ch,
   rsurf_rsp_if.source                rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ANGLE = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_TRIG  = 4'd3;
   localparam logic [3:0] S_READ  = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_SCALE = 4'd6;
   localparam logic [3:0] S_TRI1  = 4'd7;
   localparam logic [3:0] S_TRI2  = 4'd8;

   localparam int PROD_A_W = 2 * ANGLE_W;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          axis_ff;
   logic [ANGLE_W-1:0]  step_ff;
   logic [PTS_W-1:0]    pts_ff;
   logic [ANGLE_W-1:0]  sector_ff;
   logic [PROD_A_W-1:0] base_ff;
   logic [ANGLE_W-1:0]  a0_ff, a1_ff;
   trig_type            sin0_ff, cos0_ff, sin1_ff, cos1_ff;
   logic [PT_IDX_W-1:0] j_ff, j_in;
   logic                rsp_valid_ff, rsp_valid_in;
   point_type           ta_ff, tb_ff, tc_ff;
   logic                last_ff;

   logic                req_fire, out_free;
   logic [PTS_W-1:0]    pts_eff, last_idx;
   logic [PROD_A_W:0]   sum1, sum2;
   logic                sector_ok, wrap, seg_last;
   rot_ctrl_type        rot_ctrl;
   point_type           rd_data, cur0, cur1, prev0, prev1;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign pts_eff  = (pts_ff > PTS_W'(MAX_POINTS)) ? PTS_W'(MAX_POINTS) : pts_ff;
   assign last_idx = pts_eff - PTS_W'(1);
   assign seg_last = ({1'b0, j_ff} == last_idx);

   // sector range and wrap from the start angle
   assign sum1      = {1'b0, base_ff} + (PROD_A_W+1)'(step_ff);
   assign sum2      = sum1 + (PROD_A_W+1)'(step_ff);
   assign sector_ok = (step_ff != '0) && (axis_ff != 2'd3) && (pts_eff >= PTS_W'(2))
                      && (sum1 <= (PROD_A_W+1)'(FULL_TURN));
   assign wrap      = (sum2 > (PROD_A_W+1)'(FULL_TURN));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= AXIS_Z;
         step_ff <= ANGLE_W'(10);
         pts_ff  <= PTS_W'(26);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AXIS_SELECT:    axis_ff <= csr_wdata[1:0];
            CSR_ANGLE_STEP_DEG: step_ff <= csr_wdata;
            CSR_PROFILE_POINTS: pts_ff  <= csr_wdata[PTS_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rot_ctrl     = '{mul_en: 1'b0, scale_en: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_ch.kind == KIND_EMIT) begin
               state_in = S_ANGLE;
            end
         end
         S_ANGLE: state_in = S_CHECK;
         S_CHECK: state_in = sector_ok ? S_TRIG : S_IDLE;
         S_TRIG: begin
            j_in     = '0;
            state_in = S_READ;
         end
         S_READ: state_in = S_MUL;
         S_MUL: begin
            rot_ctrl.mul_en = 1'b1;
            state_in        = S_SCALE;
         end
         S_SCALE: begin
            rot_ctrl.scale_en = 1'b1;
            if (j_ff == '0) begin
               j_in     = PT_IDX_W'(1);
               state_in = S_READ;
            end else begin
               state_in = S_TRI1;
            end
         end
         S_TRI1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_TRI2;
            end
         end
         S_TRI2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (seg_last) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + PT_IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
      end
   end

   // sector angles and trig values
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sector_ff <= req_ch.sector;
      end
      if (state_ff == S_ANGLE) begin
         base_ff <= sector_ff * step_ff;
      end
      if (state_ff == S_CHECK) begin
         a0_ff <= base_ff[ANGLE_W-1:0];
         a1_ff <= wrap ? '0 : sum1[ANGLE_W-1:0];
      end
      if (state_ff == S_TRIG) begin
         sin0_ff <= sine_deg(a0_ff);
         cos0_ff <= sine_deg(a0_ff + ANGLE_W'(QUARTER_TURN));
         sin1_ff <= sine_deg(a1_ff);
         cos1_ff <= sine_deg(a1_ff + ANGLE_W'(QUARTER_TURN));
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == S_TRI1 && out_free) begin
         ta_ff   <= prev0;
         tb_ff   <= cur0;
         tc_ff   <= cur1;
         last_ff <= 1'b0;
      end else if (state_ff == S_TRI2 && out_free) begin
         ta_ff   <= prev0;
         tb_ff   <= cur1;
         tc_ff   <= prev1;
         last_ff <= seg_last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ax            = ta_ff.x;
   assign rsp_ch.ay            = ta_ff.y;
   assign rsp_ch.az            = ta_ff.z;
   assign rsp_ch.bx            = tb_ff.x;
   assign rsp_ch.by_coord      = tb_ff.y;
   assign rsp_ch.bz            = tb_ff.z;
   assign rsp_ch.cx            = tc_ff.x;
   assign rsp_ch.cy            = tc_ff.y;
   assign rsp_ch.cz            = tc_ff.z;
   assign rsp_ch.last_triangle = last_ff;

   rsurf_profile_mem u_mem (
      .clock   (clock),
      .wr_en   (req_fire && req_ch.kind == KIND_LOAD),
      .wr_addr (req_ch.point_index),
      .wr_data ({req_ch.px, req_ch.py, req_ch.pz}),
      .rd_en   (state_ff == S_READ),
      .rd_addr (j_ff),
      .rd_data (rd_data)
   );

   rsurf_rotate u_rot (
      .clock (clock),
      .ctrl  (rot_ctrl),
      .axis  (axis_ff),
      .pt    (rd_data),
      .sin0  (sin0_ff),
      .cos0  (cos0_ff),
      .sin1  (sin1_ff),
      .cos1  (cos1_ff),
      .cur0  (cur0),
      .cur1  (cur1),
      .prev0 (prev0),
      .prev1 (prev1)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/rsurf_checker.sv -----
`default_nettype none
module rsurf_checker import rsurf_pkg::*; (
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      req_kind,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire coord_type rsp_ax,
   input wire logic      rsp_last
);

   // a stalled result stays and holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ax))
      else $error("stalled result dropped or changed");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a load transfer causes no result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load produced a result");

   // mid-sector the block takes no new item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("new item taken during a sector");

endmodule

bind revolution_surface_triangulator rsurf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_kind  (req_ch.kind),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_ax    (rsp_ch.ax),
   .rsp_last  (rsp_ch.last_triangle)
);
`default_nettype wire

// ----- tb/sv/revolution_surface_triangulator_test.sv -----
`default_nettype none
module revolution_surface_triangulator_test import rsurf_pkg::*; ();

   localparam int CYCLE_LIMIT  = 3000000;
   localparam int SETTLE_TICKS = 300;

   typedef struct {
      logic                kind;
      logic [PT_IDX_W-1:0] point_index;
      coord_type           px;
      coord_type           py;
      coord_type           pz;
      logic [ANGLE_W-1:0]  sector;
   } sweep_item_type;

   typedef struct {
      coord_type corner [9];
      logic      last_triangle;
   } triangle_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rsurf_req_if req_if ();
   rsurf_rsp_if rsp_if ();

   revolution_surface_triangulator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sweep_item_type pending_items [$];
   triangle_type   expected_triangles [$];
   point_type      profile [MAX_POINTS];
   int             axis_cfg;
   int             step_cfg;
   int             points_cfg;
   int             mismatches;
   int             cycles;
   int             req_gap;
   int             rsp_gap;
   bit             quiet_tail;
   logic           req_taken;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // time limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int sine_of(int deg);
      int d;
      d = deg % FULL_TURN;
      if (d <= QUARTER_TURN) return int'(QSINE[d]);
      if (d <= HALF_TURN) return int'(QSINE[HALF_TURN - d]);
      if (d <= THREE_QUARTER_TURN) return -int'(QSINE[d - HALF_TURN]);
      return -int'(QSINE[FULL_TURN - d]);
   endfunction

   // multiply by Q2.14, round half up, saturate
   function automatic coord_type scaled(coord_type c, int t);
      longint p;
      longint q;
      p = longint'(c) * longint'(t) + ROUND_HALF;
      q = p >>> FRAC_BITS;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return coord_type'(q);
   endfunction

   function automatic point_type turned(int slot, int ang);
      point_type p;
      point_type r;
      int s;
      int c;
      p = profile[slot];
      s = sine_of(ang);
      c = sine_of(ang + QUARTER_TURN);
      if (axis_cfg == AXIS_Z) begin
         r.x = scaled(p.x, c); r.y = scaled(p.x, s); r.z = p.z;
      end else if (axis_cfg == AXIS_Y) begin
         r.x = scaled(p.x, c); r.y = p.y; r.z = scaled(p.x, s);
      end else begin
         r.x = p.x; r.y = scaled(p.z, c); r.z = scaled(p.z, s);
      end
      return r;
   endfunction

   function automatic int sector_count();
      if (step_cfg == 0) return 0;
      return FULL_TURN / step_cfg;
   endfunction

   function automatic triangle_type make_triangle(point_type a, point_type b, point_type c,
                                                  logic last);
      triangle_type t;
      t.corner = '{a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z};
      t.last_triangle = last;
      return t;
   endfunction

   // work out the triangles of one sector
   task automatic sweep_sector(int sec);
      int count;
      int pts;
      int nxt;
      int a0;
      int a1;
      point_type p00, p01, p10, p11;
      count = sector_count();
      pts = (points_cfg > MAX_POINTS) ? MAX_POINTS : points_cfg;
      if (count == 0 || axis_cfg > AXIS_X || sec >= count || pts < 2) return;
      nxt = (sec + 1) % count;
      a0 = (sec * step_cfg) % FULL_TURN;
      a1 = (nxt * step_cfg) % FULL_TURN;
      for (int j = 0; j + 1 < pts; j++) begin
         p00 = turned(j, a0);
         p01 = turned(j + 1, a0);
         p10 = turned(j, a1);
         p11 = turned(j + 1, a1);
         expected_triangles.push_back(make_triangle(p00, p01, p11, 1'b0));
         expected_triangles.push_back(make_triangle(p00, p11, p10, j + 2 == pts));
      end
   endtask

   // drive request side
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_items.size() > 0) begin
            req_if.valid       <= 1'b1;
            req_if.kind        <= pending_items[0].kind;
            req_if.point_index <= pending_items[0].point_index;
            req_if.px          <= pending_items[0].px;
            req_if.py          <= pending_items[0].py;
            req_if.pz          <= pending_items[0].pz;
            req_if.sector      <= pending_items[0].sector;
            void'(pending_items.pop_front());
            if (!quiet_tail && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 18);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // drive result-side stalls
   always @(negedge clock) begin
      if (reset || quiet_tail) begin
         rsp_if.ready <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if ($urandom_range(0, 12) == 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap <= $urandom_range(0, 17);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // predict on each request transfer
   always @(posedge clock) begin
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         if (req_if.kind == KIND_LOAD) begin
            profile[req_if.point_index] = '{req_if.px, req_if.py, req_if.pz};
         end else begin
            sweep_sector(int'(req_if.sector));
         end
      end
   end

   // check each result transfer
   always @(posedge clock) begin
      triangle_type want;
      coord_type got [9];
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.ax, rsp_if.ay, rsp_if.az, rsp_if.bx, rsp_if.by_coord, rsp_if.bz,
                 rsp_if.cx, rsp_if.cy, rsp_if.cz};
         if (expected_triangles.size() == 0) begin
            $display("%0t: unexpected triangle, actual ax %0d last %b", $time,
                     rsp_if.ax, rsp_if.last_triangle);
            mismatches++;
         end else begin
            want = expected_triangles.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (got[k] !== want.corner[k]) begin
                  $display("%0t: corner field %0d expected %0d actual %0d", $time, k,
                           want.corner[k], got[k]);
                  mismatches++;
               end
            end
            if (rsp_if.last_triangle !== want.last_triangle) begin
               $display("%0t: last_triangle expected %b actual %b", $time,
                        want.last_triangle, rsp_if.last_triangle);
               mismatches++;
            end
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_AXIS_SELECT) axis_cfg = value & 3;
      else if (idx == CSR_ANGLE_STEP_DEG) step_cfg = value & 9'h1ff;
      else points_cfg = value & 6'h3f;
   endtask

   task automatic set_sweep(int axis, int step, int pts);
      write_csr(CSR_AXIS_SELECT, axis);
      write_csr(CSR_ANGLE_STEP_DEG, step);
      write_csr(CSR_PROFILE_POINTS, pts);
   endtask

   // hold until all transfers are done, then let the block settle
   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() > 0 || req_if.valid || expected_triangles.size() > 0);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return coord_type'(-32768);
         1: return coord_type'(32767);
         2: return '0;
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic push_load(int slot, coord_type x, coord_type y, coord_type z);
      sweep_item_type it;
      it.kind = KIND_LOAD;
      it.point_index = PT_IDX_W'(slot);
      it.px = x; it.py = y; it.pz = z;
      it.sector = ANGLE_W'($urandom);
      pending_items.push_back(it);
   endtask

   task automatic push_emit(int sec);
      sweep_item_type it;
      it.kind = KIND_EMIT;
      it.point_index = PT_IDX_W'($urandom);
      it.px = coord_type'($urandom); it.py = coord_type'($urandom);
      it.pz = coord_type'($urandom);
      it.sector = ANGLE_W'(sec);
      pending_items.push_back(it);
   endtask

   // mostly emits of valid sectors, some reloads and out-of-range sectors
   task automatic random_phase(int items);
      int count;
      for (int n = 0; n < items; n++) begin
         count = sector_count();
         case ($urandom_range(0, 9))
            0, 1: push_load($urandom_range(0, MAX_POINTS - 1), rand_coord(), rand_coord(),
                            rand_coord());
            2: push_emit($urandom_range(0, 511));
            default: push_emit(count > 0 ? $urandom_range(0, count - 1) : 0);
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = KIND_LOAD;
      req_if.point_index = '0;
      req_if.px = '0;
      req_if.py = '0;
      req_if.pz = '0;
      req_if.sector = '0;
      rsp_if.ready = 1'b1;
      mismatches = 0;
      cycles = 0;
      req_gap = 0;
      rsp_gap = 0;
      quiet_tail = 1'b0;
      req_taken = 1'b0;
      axis_cfg = AXIS_Z;
      step_cfg = 10;
      points_cfg = 26;
      foreach (profile[i]) profile[i] = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // fill every slot, extremes in the first two
      push_load(0, coord_type'(-32768), coord_type'(32767), coord_type'(-32768));
      push_load(1, coord_type'(32767), coord_type'(-32768), coord_type'(32767));
      for (int s = 2; s < MAX_POINTS; s++)
         push_load(s, rand_coord(), rand_coord(), rand_coord());
      // reset settings: first, last and out-of-range sectors
      push_emit(0);
      push_emit(35);
      push_emit(36);
      push_emit(511);
      drain();

      // half turn on z: cosine of minus one on the most negative x saturates
      set_sweep(AXIS_Z, HALF_TURN, 2);
      push_emit(0);
      push_emit(1);
      drain();
      set_sweep(AXIS_Y, 1, 63);
      push_emit(359);
      push_emit(256);
      drain();
      set_sweep(AXIS_X, FULL_TURN, 32);
      push_emit(0);
      push_emit(1);
      drain();
      // nothing comes out: bad axis, zero or oversized step, too few points
      set_sweep(3, 90, 8);
      push_emit(0);
      drain();
      set_sweep(AXIS_Z, 0, 8);
      push_emit(0);
      drain();
      set_sweep(AXIS_Z, 511, 8);
      push_emit(0);
      drain();
      set_sweep(AXIS_Y, 361, 8);
      push_emit(0);
      drain();
      set_sweep(AXIS_X, 45, 1);
      push_emit(0);
      drain();
      set_sweep(AXIS_X, 45, 0);
      push_emit(7);
      drain();

      // random settings, small profiles mostly
      for (int ph = 0; ph < 9; ph++) begin
         set_sweep($urandom_range(0, 2), $urandom_range(0, 9) == 0 ? 1 : $urandom_range(1, 120),
                   $urandom_range(0, 3) == 0 ? $urandom_range(2, 63) : $urandom_range(2, 8));
         if (ph == 8) quiet_tail = 1'b1;
         random_phase(25);
         drain();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- revolution_surface_triangulator.f -----
hw/rtl/rsurf_pkg.sv
hw/rtl/rsurf_req_if.sv
hw/rtl/rsurf_rsp_if.sv
hw/rtl/rsurf_profile_mem.sv
hw/rtl/rsurf_rotate.sv
hw/rtl/revolution_surface_triangulator.sv
hw/rtl/rsurf_checker.sv
tb/sv/revolution_surface_triangulator_test.sv
